>>> rtl/stxt_pkg.sv
// Shared constants, codes and types for the signed radix text formatter.
package stxt_pkg;

   // Default symbol table capacity
   localparam int MAX_SYMBOLS_DEF = 128;

   // Field widths
   localparam int MODE_W = 2;
   localparam int CHR_W  = 8;
   localparam int NUM_W  = 32;

   // Seen map covers the 7-bit symbol code space
   localparam int SEEN_DEPTH = 128;
   localparam int SEEN_AW    = $clog2(SEEN_DEPTH);

   // Digit stack
   localparam int STACK_DEPTH = 32;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
   localparam int DIG_W       = 7;

   // Radix is at most 256, remainder below 256
   localparam int RAD_W = 9;
   localparam int REM_W = 8;

   // Divider retires this many quotient bits per cycle
   localparam int DIV_BITS_PER_CYC = 8;
   localparam int DIV_CYCLES       = NUM_W / DIV_BITS_PER_CYC;
   localparam int DIV_STEP_W       = $clog2(DIV_CYCLES);

   // Special characters and printable range
   localparam logic [CHR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHR_W-1:0] SYM_LO   = 8'd32;
   localparam logic [CHR_W-1:0] SYM_HI   = 8'd126;

   // Transaction operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_APPEND  = 2'd1,
      MODE_CONVERT = 2'd2
   } mode_type;

   // Divider request and status
   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  dividend;
      logic [RAD_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [NUM_W-1:0]  quotient;
      logic [REM_W-1:0]  remainder;
   } div_rsp_type;

endpackage

>>> rtl/stxt_req_if.sv
// Request channel: operation code, symbol byte and number to format.
interface stxt_req_if;
   logic                            valid;
   logic                            ready;
   logic [stxt_pkg::MODE_W-1:0]     mode;
   logic [stxt_pkg::CHR_W-1:0]      symbol;
   logic signed [stxt_pkg::NUM_W-1:0] number;

   modport source (output valid, output mode, output symbol, output number, input ready);
   modport sink   (input valid, input mode, input symbol, input number, output ready);
endinterface

>>> rtl/stxt_rsp_if.sv
// Response channel: one output character per transfer, last flags the final one.
interface stxt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [stxt_pkg::CHR_W-1:0]  char_out;
   logic                        last;

   modport source (output valid, output char_out, output last, input ready);
   modport sink   (input valid, input char_out, input last, output ready);
endinterface

>>> rtl/stxt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stxt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/stxt_div.sv
// Iterative divider: 32-bit dividend by 9-bit radix, eight quotient bits per cycle.
module stxt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  stxt_pkg::div_req_type div_req,
   output stxt_pkg::div_rsp_type div_rsp
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [stxt_pkg::DIV_STEP_W-1:0]   step_ff;
   logic [stxt_pkg::NUM_W-1:0]        quo_ff;
   logic [stxt_pkg::REM_W-1:0]        rem_ff;
   logic [stxt_pkg::RAD_W-1:0]        dsr_ff;

   logic [stxt_pkg::NUM_W-1:0]        quo_in;
   logic [stxt_pkg::REM_W-1:0]        rem_in;
   logic [stxt_pkg::RAD_W-1:0]        part;

   // Restoring division, one slice of quotient bits
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      part   = '0;
      for (int i = 0; i < stxt_pkg::DIV_BITS_PER_CYC; i++) begin
         part   = {rem_in, quo_in[stxt_pkg::NUM_W-1]};
         quo_in = {quo_in[stxt_pkg::NUM_W-2:0], 1'b0};
         if (part >= dsr_ff) begin
            part      = part - dsr_ff;
            quo_in[0] = 1'b1;
         end
         rem_in = part[stxt_pkg::REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            quo_ff  <= div_req.dividend;
            rem_ff  <= '0;
            dsr_ff  <= div_req.divisor;
         end else if (busy_ff) begin
            quo_ff  <= quo_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff + stxt_pkg::DIV_STEP_W'(1);
            if (step_ff == stxt_pkg::DIV_STEP_W'(stxt_pkg::DIV_CYCLES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

   // Remainder is reduced below the divisor once finished
   a_rem_below_dsr: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ({1'b0, rem_ff} < dsr_ff))
      else $error("divider remainder not below divisor");

   // No new division while one is running
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // Done follows a busy cycle
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff))
      else $error("divider done without work");

endmodule

>>> rtl/signed_int_to_radix_text.sv
// Top level: symbol table, digit stack and sequencer of the radix text formatter.
// Clear is taken in idle; append reads the seen map, then updates it in S_APPEND.
// Convert divides repeatedly and pushes each remainder digit on the stack,
// then emits the sign and one character per digit while rsp is ready.
// One transaction at a time.
// Reset clears control state and empties the symbol table; memories are not swept.
module signed_int_to_radix_text #(
   parameter int MAX_SYMBOLS = stxt_pkg::MAX_SYMBOLS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   stxt_req_if.sink      req_chan,
   stxt_rsp_if.source    rsp_chan
);

   localparam int AW    = $clog2(MAX_SYMBOLS);
   localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
   localparam int IXW   = AW + stxt_pkg::DIG_W;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_APPEND = 7'b0000010,
      S_DIV    = 7'b0000100,
      S_SIGN   = 7'b0001000,
      S_POP    = 7'b0010000,
      S_SYM    = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type                          state_ff, state_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic                               bad_ff, bad_in;
   logic                               ended_ff, ended_in;
   logic [stxt_pkg::SEEN_DEPTH-1:0]    seen_vld_ff, seen_vld_in;
   logic [stxt_pkg::CHR_W-1:0]         sym_ff, sym_in;
   logic [stxt_pkg::DEPTH_W-1:0]       depth_ff, depth_in;
   logic                               neg_ff, neg_in;
   logic                               rsp_vld_ff, rsp_vld_in;
   logic [stxt_pkg::CHR_W-1:0]         rsp_char_ff, rsp_char_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                               req_acc;
   logic                               out_free;
   logic                               out_load;
   logic                               range_bad;
   logic [stxt_pkg::NUM_W-1:0]         num_mag;
   logic [stxt_pkg::DEPTH_W-1:0]       depth_dec;

   stxt_pkg::div_req_type              div_req;
   stxt_pkg::div_rsp_type              div_rsp;

   logic                               seen_re, seen_we, seen_q;
   logic                               store_re, store_we;
   logic [AW-1:0]                      store_raddr;
   logic [stxt_pkg::CHR_W-1:0]         store_q;
   logic                               stk_re, stk_we;
   logic [stxt_pkg::DIG_W-1:0]         stk_q;
   logic [IXW-1:0]                     idx_ext;

   assign req_acc   = req_chan.valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_vld_ff || rsp_chan.ready;
   assign num_mag   = req_chan.number[stxt_pkg::NUM_W-1]
                      ? (stxt_pkg::NUM_W'(0) - stxt_pkg::NUM_W'(req_chan.number))
                      : stxt_pkg::NUM_W'(req_chan.number);
   assign depth_dec = depth_ff - stxt_pkg::DEPTH_W'(1);
   assign range_bad = (sym_ff == stxt_pkg::CH_PLUS) || (sym_ff == stxt_pkg::CH_MINUS) ||
                      (sym_ff < stxt_pkg::SYM_LO) || (sym_ff > stxt_pkg::SYM_HI);
   assign idx_ext     = IXW'(stk_q);
   assign store_raddr = idx_ext[AW-1:0];

   // Sequencer and next-state logic
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      bad_in      = bad_ff;
      ended_in    = ended_ff;
      seen_vld_in = seen_vld_ff;
      sym_in      = sym_ff;
      depth_in    = depth_ff;
      neg_in      = neg_ff;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      out_load    = 1'b0;
      seen_re     = 1'b0;
      seen_we     = 1'b0;
      store_re    = 1'b0;
      store_we    = 1'b0;
      stk_re      = 1'b0;
      stk_we      = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = div_rsp.quotient;
      div_req.divisor  = stxt_pkg::RAD_W'(count_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               case (req_chan.mode)
                  stxt_pkg::MODE_CLEAR: begin
                     count_in    = '0;
                     bad_in      = 1'b0;
                     ended_in    = 1'b0;
                     seen_vld_in = '0;
                  end
                  stxt_pkg::MODE_APPEND: begin
                     if (!ended_ff) begin
                        if (req_chan.symbol == stxt_pkg::CH_NUL) begin
                           ended_in = 1'b1;
                        end else if (count_ff >= CNT_W'(MAX_SYMBOLS)) begin
                           bad_in = 1'b1;
                        end else begin
                           seen_re  = 1'b1;
                           sym_in   = req_chan.symbol;
                           state_in = S_APPEND;
                        end
                     end
                  end
                  stxt_pkg::MODE_CONVERT: begin
                     if (!bad_ff && (count_ff >= CNT_W'(2))) begin
                        div_req.start    = 1'b1;
                        div_req.dividend = num_mag;
                        neg_in   = req_chan.number[stxt_pkg::NUM_W-1];
                        depth_in = '0;
                        state_in = S_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Seen-map data is back: judge the symbol and store it
         S_APPEND: begin
            if (range_bad) begin
               bad_in = 1'b1;
            end else begin
               if (seen_q && seen_vld_ff[sym_ff[stxt_pkg::SEEN_AW-1:0]]) begin
                  bad_in = 1'b1;
               end
               seen_we = 1'b1;
               seen_vld_in[sym_ff[stxt_pkg::SEEN_AW-1:0]] = 1'b1;
            end
            store_we = 1'b1;
            count_in = count_ff + CNT_W'(1);
            state_in = S_IDLE;
         end
         // Push each remainder, divide again until the quotient is zero or the stack is full
         S_DIV: begin
            if (div_rsp.done) begin
               stk_we   = 1'b1;
               depth_in = depth_ff + stxt_pkg::DEPTH_W'(1);
               if ((div_rsp.quotient != '0) &&
                   (depth_ff != stxt_pkg::DEPTH_W'(stxt_pkg::STACK_DEPTH - 1))) begin
                  div_req.start = 1'b1;
               end else begin
                  state_in = S_SIGN;
               end
            end
         end
         S_SIGN: begin
            if (!neg_ff) begin
               state_in = S_POP;
            end else if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = stxt_pkg::CH_MINUS;
               rsp_last_in = 1'b0;
               state_in    = S_POP;
            end
         end
         // Pop a digit, look up its symbol, hand it out
         S_POP: begin
            stk_re   = 1'b1;
            depth_in = depth_dec;
            state_in = S_SYM;
         end
         S_SYM: begin
            store_re = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = store_q;
               rsp_last_in = (depth_ff == '0);
               state_in    = (depth_ff == '0) ? S_IDLE : S_POP;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_vld_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         bad_ff      <= 1'b0;
         ended_ff    <= 1'b0;
         seen_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
         depth_ff    <= '0;
         neg_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         bad_ff      <= bad_in;
         ended_ff    <= ended_in;
         seen_vld_ff <= seen_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         depth_ff    <= depth_in;
         neg_ff      <= neg_in;
      end
      sym_ff      <= sym_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Symbol table
   stxt_ram #(
      .WIDTH (stxt_pkg::CHR_W),
      .DEPTH (MAX_SYMBOLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (sym_ff),
      .rd_en   (store_re),
      .rd_addr (store_raddr),
      .rd_data (store_q)
   );

   // Seen map, qualified by per-entry valid bits cleared on clear
   stxt_ram #(
      .WIDTH (1),
      .DEPTH (stxt_pkg::SEEN_DEPTH)
   ) u_seen (
      .clock   (clock),
      .wr_en   (seen_we),
      .wr_addr (sym_ff[stxt_pkg::SEEN_AW-1:0]),
      .wr_data (1'b1),
      .rd_en   (seen_re),
      .rd_addr (req_chan.symbol[stxt_pkg::SEEN_AW-1:0]),
      .rd_data (seen_q)
   );

   // Digit stack, least significant first
   stxt_ram #(
      .WIDTH (stxt_pkg::DIG_W),
      .DEPTH (stxt_pkg::STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (depth_ff[stxt_pkg::STK_AW-1:0]),
      .wr_data (div_rsp.remainder[stxt_pkg::DIG_W-1:0]),
      .rd_en   (stk_re),
      .rd_addr (depth_dec[stxt_pkg::STK_AW-1:0]),
      .rd_data (stk_q)
   );

   stxt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_vld_ff;
   assign rsp_chan.char_out = rsp_char_ff;
   assign rsp_chan.last     = rsp_last_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SYMBOLS))
      else $error("symbol count above capacity");

   a_ended_src: assert property (@(posedge clock) disable iff (reset)
      $rose(ended_ff) |-> $past(req_acc && (req_chan.mode == stxt_pkg::MODE_APPEND) &&
                                (req_chan.symbol == stxt_pkg::CH_NUL)))
      else $error("table ended without a zero symbol");

   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !div_rsp.busy)
      else $error("ready while divider busy");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      stk_we |-> (depth_ff < stxt_pkg::DEPTH_W'(stxt_pkg::STACK_DEPTH)))
      else $error("digit stack overflow");

endmodule
